/* hdl/lpd_pkg.sv */
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants of the link packet deframer: sync codes, event
// codes, register indexes and the result record.
// ----------------------------------------------------------------------------
package lpd_pkg;

  // Largest payload length the deframer ever accepts.
  localparam int unsigned MAX_PAYLOAD = 64;

  // Sync pair that opens every frame.
  localparam logic [7:0] SYNC_FIRST  = 8'hBC;
  localparam logic [7:0] SYNC_SECOND = 8'hCF;

  // Register reset values.
  localparam logic [7:0] BATTERY_TYPE_RST = 8'h13;
  localparam logic [6:0] MAX_LENGTH_RST   = 7'd64;

  // Configuration register indexes.
  localparam logic REG_BATTERY_TYPE = 1'b0;
  localparam logic REG_MAX_LENGTH   = 1'b1;

  // Event codes carried in each result item.
  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_BYTE  = 3'd1;
  localparam logic [2:0] EV_GOOD  = 3'd2;
  localparam logic [2:0] EV_CKERR = 3'd3;
  localparam logic [2:0] EV_LONG  = 3'd4;

  // Configuration register contents.
  typedef struct packed {
    logic [7:0] battery_type;
    logic [6:0] max_length;
  } lpd_cfg_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  payload_byte;
    logic [5:0]  payload_index;
    logic [7:0]  frame_type;
    logic [6:0]  frame_length;
    logic        voltage_valid;
    logic [31:0] voltage_bits;
    logic [31:0] bytes_seen;
    logic [31:0] sync_starts;
    logic [31:0] good_packets;
    logic [31:0] checksum_failures;
    logic [7:0]  last_good_type;
  } lpd_result_t;

endpackage

/* hdl/lpd_ifs.sv */
// ----------------------------------------------------------------------------
// lpd_rx_if / lpd_res_if
// Valid/ready channels of the deframer: received bytes in, result items out.
// ----------------------------------------------------------------------------
interface lpd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_data;

  modport source (output valid, output rx_data, input ready);
  modport sink   (input valid, input rx_data, output ready);
endinterface

interface lpd_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  payload_byte;
  logic [5:0]  payload_index;
  logic [7:0]  frame_type;
  logic [6:0]  frame_length;
  logic        voltage_valid;
  logic [31:0] voltage_bits;
  logic [31:0] bytes_seen;
  logic [31:0] sync_starts;
  logic [31:0] good_packets;
  logic [31:0] checksum_failures;
  logic [7:0]  last_good_type;

  modport source (output valid, output event_res, output payload_byte,
                  output payload_index, output frame_type, output frame_length,
                  output voltage_valid, output voltage_bits, output bytes_seen,
                  output sync_starts, output good_packets,
                  output checksum_failures, output last_good_type,
                  input ready);
  modport sink   (input valid, input event_res, input payload_byte,
                  input payload_index, input frame_type, input frame_length,
                  input voltage_valid, input voltage_bits, input bytes_seen,
                  input sync_starts, input good_packets,
                  input checksum_failures, input last_good_type,
                  output ready);
endinterface

/* hdl/lpd_cfg.sv */
// ----------------------------------------------------------------------------
// lpd_cfg
// Configuration registers: battery frame type and payload length limit.
// ----------------------------------------------------------------------------
module lpd_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [7:0]       cfg_wdata,
  output lpd_pkg::lpd_cfg_t cfg
);

  // Register writes; upper bits of the length limit write are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.battery_type <= lpd_pkg::BATTERY_TYPE_RST;
      cfg.max_length   <= lpd_pkg::MAX_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        lpd_pkg::REG_BATTERY_TYPE: cfg.battery_type <= cfg_wdata;
        lpd_pkg::REG_MAX_LENGTH:   cfg.max_length   <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

endmodule

/* hdl/lpd_in_stage.sv */
// ----------------------------------------------------------------------------
// lpd_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module lpd_in_stage (
  input  logic       clk,
  input  logic       rst,
  lpd_rx_if.sink     rx,
  output logic       s_valid,
  output logic [7:0] s_data,
  input  logic       s_ready
);

  // The register may load when it is empty or is being drained this cycle.
  assign rx.ready = !s_valid || s_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (rx.ready) begin
      s_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s_data <= rx.rx_data;
    end
  end

endmodule

/* hdl/lpd_parser.sv */
// ----------------------------------------------------------------------------
// lpd_parser
// Frame state machine, running checksums, voltage latch and event counters.
// Consumes one byte per cycle whenever it fires, and produces the matching result item.
// ----------------------------------------------------------------------------
module lpd_parser #(
  parameter int unsigned MAX_PAYLOAD = lpd_pkg::MAX_PAYLOAD
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lpd_pkg::lpd_cfg_t    cfg,
  input  logic                 fire,
  input  logic [7:0]           b,
  output lpd_pkg::lpd_result_t result
);

  localparam logic [2:0] PH_HUNT1 = 3'd0;
  localparam logic [2:0] PH_HUNT2 = 3'd1;
  localparam logic [2:0] PH_TYPE  = 3'd2;
  localparam logic [2:0] PH_LEN   = 3'd3;
  localparam logic [2:0] PH_DATA  = 3'd4;
  localparam logic [2:0] PH_CKA   = 3'd5;
  localparam logic [2:0] PH_CKB   = 3'd6;

  localparam logic [7:0] MAX_PAYLOAD_B = 8'(MAX_PAYLOAD);

  logic [2:0]  phase,      phase_next;
  logic [7:0]  cur_type,   cur_type_next;
  logic [6:0]  cur_length, cur_length_next;
  logic [6:0]  byte_index, byte_index_next;
  logic [7:0]  sum_a,      sum_a_next;
  logic [7:0]  sum_b,      sum_b_next;
  logic [31:0] staging,    staging_next;
  logic [31:0] volt_word,  volt_word_next;
  logic        volt_seen,  volt_seen_next;
  logic [31:0] cnt_bytes,  cnt_bytes_next;
  logic [31:0] cnt_sync,   cnt_sync_next;
  logic [31:0] cnt_good,   cnt_good_next;
  logic [31:0] cnt_fail,   cnt_fail_next;
  logic [7:0]  last_type,  last_type_next;

  logic [2:0]  ev;
  logic [7:0]  pbyte;
  logic [5:0]  pidx;
  logic [7:0]  limit;
  logic [7:0]  sum_a_len;
  logic [7:0]  sum_a_dat;
  logic [7:0]  index_inc;

  // Effective length limit is the smaller of the register and the build limit.
  assign limit = ({1'b0, cfg.max_length} < MAX_PAYLOAD_B) ? {1'b0, cfg.max_length}
                                                          : MAX_PAYLOAD_B;
  assign sum_a_len = sum_a + b;
  assign sum_a_dat = sum_a + b;
  assign index_inc = {1'b0, byte_index} + 8'd1;

  // Next-state logic for one byte.
  always_comb begin
    phase_next      = phase;
    cur_type_next   = cur_type;
    cur_length_next = cur_length;
    byte_index_next = byte_index;
    sum_a_next      = sum_a;
    sum_b_next      = sum_b;
    staging_next    = staging;
    volt_word_next  = volt_word;
    volt_seen_next  = volt_seen;
    cnt_bytes_next  = cnt_bytes + 32'd1;
    cnt_sync_next   = cnt_sync;
    cnt_good_next   = cnt_good;
    cnt_fail_next   = cnt_fail;
    last_type_next  = last_type;
    ev              = lpd_pkg::EV_NONE;
    pbyte           = 8'd0;
    pidx            = 6'd0;

    case (phase)
      PH_HUNT2: begin
        phase_next = (b == lpd_pkg::SYNC_SECOND) ? PH_TYPE : PH_HUNT1;
      end
      PH_TYPE: begin
        cur_type_next = b;
        sum_a_next    = b;
        sum_b_next    = b;
        phase_next    = PH_LEN;
      end
      PH_LEN: begin
        cur_length_next = b[7] ? 7'd127 : b[6:0];
        sum_a_next      = sum_a_len;
        sum_b_next      = sum_b + sum_a_len;
        byte_index_next = 7'd0;
        if (b > limit) begin
          ev         = lpd_pkg::EV_LONG;
          phase_next = PH_HUNT1;
        end else if (b != 8'd0) begin
          phase_next = PH_DATA;
        end else begin
          phase_next = PH_CKA;
        end
      end
      PH_DATA: begin
        ev    = lpd_pkg::EV_BYTE;
        pbyte = b;
        pidx  = byte_index[5:0];
        // Payload bytes one to four form the little-endian voltage word.
        case (byte_index)
          7'd1:    staging_next[7:0]   = b;
          7'd2:    staging_next[15:8]  = b;
          7'd3:    staging_next[23:16] = b;
          7'd4:    staging_next[31:24] = b;
          default: ;
        endcase
        byte_index_next = index_inc[6:0];
        sum_a_next      = sum_a_dat;
        sum_b_next      = sum_b + sum_a_dat;
        if (index_inc >= {1'b0, cur_length}) begin
          phase_next = PH_CKA;
        end
      end
      PH_CKA: begin
        if (b == sum_a) begin
          phase_next = PH_CKB;
        end else begin
          ev            = lpd_pkg::EV_CKERR;
          cnt_fail_next = cnt_fail + 32'd1;
          phase_next    = PH_HUNT1;
        end
      end
      PH_CKB: begin
        if (b == sum_b) begin
          ev             = lpd_pkg::EV_GOOD;
          cnt_good_next  = cnt_good + 32'd1;
          last_type_next = cur_type;
          if (cur_type == cfg.battery_type && cur_length >= 7'd5) begin
            volt_word_next = staging;
            volt_seen_next = 1'b1;
          end
        end else begin
          ev            = lpd_pkg::EV_CKERR;
          cnt_fail_next = cnt_fail + 32'd1;
        end
        phase_next = PH_HUNT1;
      end
      default: begin
        // Hunting for the first sync byte; unused codes land here too.
        phase_next = PH_HUNT1;
        if (b == lpd_pkg::SYNC_FIRST) begin
          cnt_sync_next = cnt_sync + 32'd1;
          phase_next    = PH_HUNT2;
        end
      end
    endcase
  end

  // State update, one byte per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT1;
      cur_type   <= 8'd0;
      cur_length <= 7'd0;
      byte_index <= 7'd0;
      sum_a      <= 8'd0;
      sum_b      <= 8'd0;
      staging    <= 32'd0;
      volt_word  <= 32'd0;
      volt_seen  <= 1'b0;
      cnt_bytes  <= 32'd0;
      cnt_sync   <= 32'd0;
      cnt_good   <= 32'd0;
      cnt_fail   <= 32'd0;
      last_type  <= 8'd0;
    end else if (fire) begin
      phase      <= phase_next;
      cur_type   <= cur_type_next;
      cur_length <= cur_length_next;
      byte_index <= byte_index_next;
      sum_a      <= sum_a_next;
      sum_b      <= sum_b_next;
      staging    <= staging_next;
      volt_word  <= volt_word_next;
      volt_seen  <= volt_seen_next;
      cnt_bytes  <= cnt_bytes_next;
      cnt_sync   <= cnt_sync_next;
      cnt_good   <= cnt_good_next;
      cnt_fail   <= cnt_fail_next;
      last_type  <= last_type_next;
    end
  end

  // The result reflects the state after this byte.
  always_comb begin
    result.event_res         = ev;
    result.payload_byte      = pbyte;
    result.payload_index     = pidx;
    result.frame_type        = cur_type_next;
    result.frame_length      = cur_length_next;
    result.voltage_valid     = volt_seen_next;
    result.voltage_bits      = volt_word_next;
    result.bytes_seen        = cnt_bytes_next;
    result.sync_starts       = cnt_sync_next;
    result.good_packets      = cnt_good_next;
    result.checksum_failures = cnt_fail_next;
    result.last_good_type    = last_type_next;
  end

endmodule

/* hdl/lpd_out_stage.sv */
// ----------------------------------------------------------------------------
// lpd_out_stage
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module lpd_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lpd_pkg::lpd_result_t in_result,
  lpd_res_if.source            res
);

  lpd_pkg::lpd_result_t held;

  // Loads when empty or when the held item leaves this cycle.
  assign in_ready = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (in_ready) begin
      res.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held <= in_result;
    end
  end

  // Drive the channel fields from the held item.
  assign res.event_res         = held.event_res;
  assign res.payload_byte      = held.payload_byte;
  assign res.payload_index     = held.payload_index;
  assign res.frame_type        = held.frame_type;
  assign res.frame_length      = held.frame_length;
  assign res.voltage_valid     = held.voltage_valid;
  assign res.voltage_bits      = held.voltage_bits;
  assign res.bytes_seen        = held.bytes_seen;
  assign res.sync_starts       = held.sync_starts;
  assign res.good_packets      = held.good_packets;
  assign res.checksum_failures = held.checksum_failures;
  assign res.last_good_type    = held.last_good_type;

endmodule

/* hdl/link_packet_deframer_core.sv */
// ----------------------------------------------------------------------------
// link_packet_deframer_core
// Byte-serial frame receiver with two-byte sync, running-sum checksums,
// battery voltage latch and wrapping event counters.
// ----------------------------------------------------------------------------
// Each received byte yields exactly one result item. An accepted byte is held
// in the input register while the frame parser works on it, and its result
// loads into the result register when that register can take it; the result
// is offered from there. A new byte is taken every cycle as long as the
// result side keeps up; the only bound on rate is the single parser update
// per byte, so throughput is one byte per clock. When the result side stalls,
// the two registers hold two bytes and the input stalls until results move.
// MAX_PAYLOAD caps the accepted payload length on top of the max_length
// register. Configuration writes take effect on the next byte the parser
// sees and should be made while idle.
// ----------------------------------------------------------------------------
module link_packet_deframer_core #(
  parameter int unsigned MAX_PAYLOAD = lpd_pkg::MAX_PAYLOAD
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_idx,
  input  logic [7:0] cfg_wdata,
  lpd_rx_if.sink     rx,
  lpd_res_if.source  res
);

  lpd_pkg::lpd_cfg_t    cfg;
  lpd_pkg::lpd_result_t parse_result;
  logic                 s_valid;
  logic [7:0]           s_data;
  logic                 o_ready;

  // Configuration registers.
  lpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register.
  lpd_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .s_valid (s_valid),
    .s_data  (s_data),
    .s_ready (o_ready)
  );

  // Frame parser; it advances whenever it holds a byte and the result register can load.
  lpd_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (s_valid && o_ready),
    .b      (s_data),
    .result (parse_result)
  );

  // Result register.
  lpd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_ready  (o_ready),
    .in_result (parse_result),
    .res       (res)
  );

endmodule

/* hdl/lpd_checker.sv */
// ----------------------------------------------------------------------------
// lpd_checker
// Port-level checks on the deframer result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lpd_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic [2:0] event_res,
  input logic [7:0] payload_byte,
  input logic [5:0] payload_index,
  input logic [7:0] frame_type,
  input logic       voltage_valid,
  input logic [7:0] last_good_type
);

  // No result item can be pending right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // Event code stays within the defined set.
  a_event_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (event_res == lpd_pkg::EV_NONE || event_res == lpd_pkg::EV_BYTE ||
                   event_res == lpd_pkg::EV_GOOD || event_res == lpd_pkg::EV_CKERR ||
                   event_res == lpd_pkg::EV_LONG))
    else $error("undefined event code");

  // Payload fields are zero for every event but a payload byte.
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && event_res != lpd_pkg::EV_BYTE) |->
      (payload_byte == 8'd0 && payload_index == 6'd0))
    else $error("payload fields set outside a payload byte");

  // A good frame records its own type as the last good type.
  a_good_type: assert property (@(posedge clk) disable iff (rst)
    (res_valid && event_res == lpd_pkg::EV_GOOD) |-> (last_good_type == frame_type))
    else $error("last good type differs from frame type");

  // The voltage flag is sticky across result items.
  a_volt_sticky: assert property (@(posedge clk) disable iff (rst)
    (res_valid && voltage_valid) |=> (!res_valid || voltage_valid))
    else $error("voltage flag cleared");

endmodule

bind link_packet_deframer_core lpd_checker u_lpd_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res.valid),
  .event_res      (res.event_res),
  .payload_byte   (res.payload_byte),
  .payload_index  (res.payload_index),
  .frame_type     (res.frame_type),
  .voltage_valid  (res.voltage_valid),
  .last_good_type (res.last_good_type)
);

/* tb/tb_link_packet_deframer_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_link_packet_deframer_core
// Self-checking bench for the byte-serial frame receiver. Bytes go in as
// frames with random content, broken frames and noise. A behavioral copy of
// the parser predicts one result item per byte. Each result is checked field
// by field against that prediction, under random idling on both channels
// and one long stall of the result side.
// ----------------------------------------------------------------------------
module tb_link_packet_deframer_core;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES = 250;

  // Parser phases of the behavioral copy.
  typedef enum logic [2:0] {
    PH_HUNT_FIRST, PH_HUNT_SECOND, PH_TYPE, PH_LENGTH, PH_PAYLOAD, PH_CHECK_A, PH_CHECK_B
  } parse_phase_e;

  // Ways a generated frame can be spoiled.
  typedef enum logic [1:0] {FR_GOOD, FR_BAD_A, FR_BAD_B, FR_CUT} frame_fault_e;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_idx;
  logic [7:0] cfg_wdata;

  lpd_rx_if  rx_ch ();
  lpd_res_if res_ch ();

  link_packet_deframer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .rx        (rx_ch),
    .res       (res_ch)
  );

  // Register contents as the bench believes them to be.
  logic [7:0] cfg_battery = lpd_pkg::BATTERY_TYPE_RST;
  logic [6:0] cfg_max_len = lpd_pkg::MAX_LENGTH_RST;

  // Behavioral parser state.
  parse_phase_e phase      = PH_HUNT_FIRST;
  logic [7:0]   frm_type   = '0;
  logic [6:0]   frm_len    = '0;
  logic [6:0]   pay_idx    = '0;
  logic [7:0]   run_a      = '0;
  logic [7:0]   run_b      = '0;
  logic [31:0]  volt_stage = '0;
  logic [31:0]  volt_word  = '0;
  logic         volt_seen  = 1'b0;
  logic [31:0]  cnt_bytes  = '0;
  logic [31:0]  cnt_sync   = '0;
  logic [31:0]  cnt_good   = '0;
  logic [31:0]  cnt_ckerr  = '0;
  logic [7:0]   last_type  = '0;

  lpd_pkg::lpd_result_t predicted_results[$];
  lpd_pkg::lpd_result_t want;

  int unsigned n_fail = 0;
  int unsigned n_sent = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Advance the parser copy by one received byte and return its result item.
  function automatic lpd_pkg::lpd_result_t deframe_byte(input logic [7:0] b);
    lpd_pkg::lpd_result_t r;
    int unsigned limit;
    r = '0;
    r.event_res = lpd_pkg::EV_NONE;
    cnt_bytes++;
    case (phase)
      PH_HUNT_SECOND: begin
        phase = (b == lpd_pkg::SYNC_SECOND) ? PH_TYPE : PH_HUNT_FIRST;
      end
      PH_TYPE: begin
        frm_type = b;
        run_a = b;
        run_b = b;
        phase = PH_LENGTH;
      end
      PH_LENGTH: begin
        frm_len = (b > 8'd127) ? 7'd127 : b[6:0];
        run_a = run_a + b;
        run_b = run_b + run_a;
        pay_idx = '0;
        limit = (cfg_max_len < lpd_pkg::MAX_PAYLOAD) ? cfg_max_len : lpd_pkg::MAX_PAYLOAD;
        if (b > limit) begin
          r.event_res = lpd_pkg::EV_LONG;
          phase = PH_HUNT_FIRST;
        end else if (b != 8'd0) begin
          phase = PH_PAYLOAD;
        end else begin
          phase = PH_CHECK_A;
        end
      end
      PH_PAYLOAD: begin
        r.event_res = lpd_pkg::EV_BYTE;
        r.payload_byte = b;
        r.payload_index = pay_idx[5:0];
        // Payload bytes 1..4 form the little-endian voltage word.
        if (pay_idx >= 7'd1 && pay_idx <= 7'd4) begin
          volt_stage[(pay_idx - 7'd1) * 8 +: 8] = b;
        end
        pay_idx = pay_idx + 7'd1;
        run_a = run_a + b;
        run_b = run_b + run_a;
        if (pay_idx >= frm_len) begin
          phase = PH_CHECK_A;
        end
      end
      PH_CHECK_A: begin
        if (b == run_a) begin
          phase = PH_CHECK_B;
        end else begin
          r.event_res = lpd_pkg::EV_CKERR;
          cnt_ckerr++;
          phase = PH_HUNT_FIRST;
        end
      end
      PH_CHECK_B: begin
        if (b == run_b) begin
          r.event_res = lpd_pkg::EV_GOOD;
          cnt_good++;
          last_type = frm_type;
          if (frm_type == cfg_battery && frm_len >= 7'd5) begin
            volt_word = volt_stage;
            volt_seen = 1'b1;
          end
        end else begin
          r.event_res = lpd_pkg::EV_CKERR;
          cnt_ckerr++;
        end
        phase = PH_HUNT_FIRST;
      end
      default: begin
        phase = PH_HUNT_FIRST;
        if (b == lpd_pkg::SYNC_FIRST) begin
          cnt_sync++;
          phase = PH_HUNT_SECOND;
        end
      end
    endcase
    r.frame_type = frm_type;
    r.frame_length = frm_len;
    r.voltage_valid = volt_seen;
    r.voltage_bits = volt_word;
    r.bytes_seen = cnt_bytes;
    r.sync_starts = cnt_sync;
    r.good_packets = cnt_good;
    r.checksum_failures = cnt_ckerr;
    r.last_good_type = last_type;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      n_fail++;
    end
  endfunction

  // Offer one byte, with a random gap unless running at full rate, and
  // predict its result once it is taken.
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 29) begin
      rx_ch.valid <= 1'b0;
      @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_data <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    predicted_results.push_back(deframe_byte(b));
    n_sent++;
  endtask

  // Build a frame around the given length byte and payload and send it.
  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] len_byte,
                            input logic [7:0] pay[$], input frame_fault_e fault);
    logic [7:0] fb[$];
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    fb = {lpd_pkg::SYNC_FIRST, lpd_pkg::SYNC_SECOND, ftype, len_byte};
    ck_a = ftype + len_byte;
    ck_b = ftype + ck_a;
    // Frames longer than MAX_PAYLOAD are cut right after the length byte.
    if (len_byte <= lpd_pkg::MAX_PAYLOAD) begin
      foreach (pay[i]) begin
        fb.push_back(pay[i]);
        ck_a = ck_a + pay[i];
        ck_b = ck_b + ck_a;
      end
      if (fault == FR_BAD_A) ck_a = ck_a ^ 8'($urandom_range(1, 255));
      if (fault == FR_BAD_B) ck_b = ck_b ^ 8'($urandom_range(1, 255));
      fb.push_back(ck_a);
      fb.push_back(ck_b);
    end
    if (fault == FR_CUT) fb = fb[0:$urandom_range(0, fb.size() - 2)];
    foreach (fb[i]) send_byte(fb[i]);
  endtask

  // Stop offering and wait until every predicted result has come out.
  task automatic drain();
    rx_ch.valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == lpd_pkg::REG_BATTERY_TYPE) cfg_battery = val;
    else cfg_max_len = val[6:0];
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] battery, input logic [6:0] max_len);
    drain();
    write_reg(lpd_pkg::REG_BATTERY_TYPE, battery);
    write_reg(lpd_pkg::REG_MAX_LENGTH, {1'b0, max_len});
  endtask

  // Mostly frames with random content, some of them broken, mixed with line noise.
  task automatic stream_traffic(input int unsigned n_bytes);
    int unsigned start;
    int unsigned pick;
    int unsigned limit;
    int unsigned plen;
    logic [7:0] ftype;
    logic [7:0] pay[$];
    frame_fault_e fault;
    start = n_sent;
    while (n_sent - start < n_bytes) begin
      pick = $urandom_range(0, 99);
      limit = (cfg_max_len < lpd_pkg::MAX_PAYLOAD) ? cfg_max_len : lpd_pkg::MAX_PAYLOAD;
      if (pick < 85) begin
        ftype = ($urandom_range(0, 99) < 40) ? cfg_battery : 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 85) plen = $urandom_range(0, (limit < 8) ? limit : 8);
        else if (pick < 95) plen = $urandom_range(0, limit);
        else plen = $urandom_range(limit + 1, 255);
        pay = {};
        for (int i = 0; i < plen && plen <= lpd_pkg::MAX_PAYLOAD; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 10) pay.push_back(8'h00);
          else if (pick < 20) pay.push_back(8'hFF);
          else if (pick < 25) pay.push_back(lpd_pkg::SYNC_FIRST);
          else pay.push_back(8'($urandom_range(0, 255)));
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) fault = FR_GOOD;
        else if (pick < 80) fault = FR_BAD_A;
        else if (pick < 90) fault = FR_BAD_B;
        else fault = FR_CUT;
        send_frame(ftype, 8'(plen), pay, fault);
      end else begin
        // Line noise, with first sync bytes sprinkled in.
        repeat ($urandom_range(1, 4)) begin
          send_byte(($urandom_range(0, 99) < 20) ? lpd_pkg::SYNC_FIRST
                                                 : 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // Hand-picked frames covering each event and special case.
  task automatic test_directed_frames();
    logic [7:0] pay[$];
    // Good battery frame: voltage word latched from bytes 1..4.
    pay = {8'h00, 8'h11, 8'h22, 8'h33, 8'hFF};
    send_frame(lpd_pkg::BATTERY_TYPE_RST, 8'd5, pay, FR_GOOD);
    // A repeated first sync byte is not taken as a fresh first sync byte.
    send_byte(lpd_pkg::SYNC_FIRST);
    send_byte(lpd_pkg::SYNC_FIRST);
    send_byte(lpd_pkg::SYNC_SECOND);
    // Zero-length frames, one good and one with a bad second check byte.
    pay = {};
    send_frame(8'hFF, 8'd0, pay, FR_GOOD);
    send_frame(8'h00, 8'd0, pay, FR_BAD_B);
    // Length byte far over the limit, shown saturated.
    send_frame(8'h07, 8'hFF, pay, FR_GOOD);
    // Bad first check byte.
    pay = {8'h80};
    send_frame(8'h01, 8'd1, pay, FR_BAD_A);
  endtask

  task automatic test_random_traffic(input logic [7:0] battery, input logic [6:0] max_len,
                                     input int unsigned n_bytes);
    set_config(battery, max_len);
    stream_traffic(n_bytes);
  endtask

  // No gaps on either side for a long stretch.
  task automatic test_full_rate(input int unsigned n_bytes);
    calm = 1'b1;
    stream_traffic(n_bytes);
    calm = 1'b0;
  endtask

  // The result side stops for a long while as bytes keep coming.
  task automatic test_back_pressure();
    calm = 1'b1;
    hold_reqs <= hold_reqs + 1;
    stream_traffic(150);
    calm = 1'b0;
  endtask

  // Result side ready, with random stalls and requested long hold-offs.
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= calm || ($urandom_range(0, 99) >= 29);
    end
  end

  // Compare each result item with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (predicted_results.size() == 0) begin
        $error("result item with no prediction waiting");
        n_fail++;
      end else begin
        want = predicted_results.pop_front();
        check_field("event_res", want.event_res, res_ch.event_res);
        check_field("payload_byte", want.payload_byte, res_ch.payload_byte);
        check_field("payload_index", want.payload_index, res_ch.payload_index);
        check_field("frame_type", want.frame_type, res_ch.frame_type);
        check_field("frame_length", want.frame_length, res_ch.frame_length);
        check_field("voltage_valid", want.voltage_valid, res_ch.voltage_valid);
        check_field("voltage_bits", want.voltage_bits, res_ch.voltage_bits);
        check_field("bytes_seen", want.bytes_seen, res_ch.bytes_seen);
        check_field("sync_starts", want.sync_starts, res_ch.sync_starts);
        check_field("good_packets", want.good_packets, res_ch.good_packets);
        check_field("checksum_failures", want.checksum_failures, res_ch.checksum_failures);
        check_field("last_good_type", want.last_good_type, res_ch.last_good_type);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** link_packet_deframer_core: FAILED **");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = lpd_pkg::REG_BATTERY_TYPE;
    cfg_wdata = '0;
    rx_ch.valid = 1'b0;
    rx_ch.rx_data = '0;
    res_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_frames();
    test_random_traffic(lpd_pkg::BATTERY_TYPE_RST, lpd_pkg::MAX_LENGTH_RST, 300);
    test_random_traffic(8'h00, 7'd0, 200);
    test_random_traffic(8'hFF, 7'd64, 300);
    test_random_traffic(8'($urandom_range(0, 255)), 7'd5, 250);
    set_config(8'($urandom_range(0, 255)), 7'($urandom_range(1, 64)));
    test_full_rate(300);
    test_back_pressure();
    test_random_traffic(8'($urandom_range(0, 255)), 7'($urandom_range(0, 64)), 200);
    drain();

    if (n_fail == 0) begin
      $display("** link_packet_deframer_core: PASSED **");
    end else begin
      $display("** link_packet_deframer_core: FAILED **");
    end
    $finish;
  end

endmodule
